### sv/dbe_pkg.sv
// ----------------------------------------------------------------------------
// dbe_pkg: shared types and constants for the button debounce block
// Holds the history depth, field widths and the poll and result item types.
// ----------------------------------------------------------------------------
package dbe_pkg;

    // number of samples a button must agree on before the held bit changes
    localparam int HISTORY_DEPTH = 3;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int BTN_W         = 8;

    localparam logic [BTN_W-1:0] MASK_RESET = 8'hFF;
    localparam logic [BTN_W-1:0] RAW_RESET  = 8'hFF;

    // one poll item as held in the input register
    typedef struct packed {
        logic             poll_valid;
        logic [BTN_W-1:0] raw_gpio;
        logic             read_ok;
        logic             prime;
        logic             take_pressed;
        logic             take_released;
    } t_poll;

    // one result item
    typedef struct packed {
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] pressed_edges;
        logic [BTN_W-1:0] released_edges;
        logic [BTN_W-1:0] raw_last;
        logic             online;
    } t_result;

endpackage

### sv/dbe_if.sv
// ----------------------------------------------------------------------------
// dbe_poll_if / dbe_result_if: valid-ready channels of the debounce block
// The poll channel carries one raw port read, the result channel one report.
// ----------------------------------------------------------------------------
interface dbe_poll_if;
    logic       valid;
    logic       ready;
    logic       poll_valid;
    logic [7:0] raw_gpio;
    logic       read_ok;
    logic       prime;
    logic       take_pressed;
    logic       take_released;

    modport source (output valid, output poll_valid, output raw_gpio, output read_ok,
                    output prime, output take_pressed, output take_released,
                    input ready);
    modport sink   (input valid, input poll_valid, input raw_gpio, input read_ok,
                    input prime, input take_pressed, input take_released,
                    output ready);
endinterface

interface dbe_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] held;
    logic [7:0] pressed_edges;
    logic [7:0] released_edges;
    logic [7:0] raw_last;
    logic       online;

    modport source (output valid, output held, output pressed_edges,
                    output released_edges, output raw_last, output online,
                    input ready);
    modport sink   (input valid, input held, input pressed_edges,
                    input released_edges, input raw_last, input online,
                    output ready);
endinterface

### sv/dbe_in_stage.sv
// ----------------------------------------------------------------------------
// dbe_in_stage: input register of the debounce block
// Captures one poll transfer and holds it until the filter stage takes it.
// ----------------------------------------------------------------------------
module dbe_in_stage
    import dbe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dbe_poll_if.sink     i_poll,
    input  logic         i_advance,
    output logic         o_valid,
    output t_poll        o_item
);

    logic  r_valid;
    logic  n_valid;
    t_poll r_item;
    logic  w_take;

    // free slot, or the held item leaves this cycle
    assign i_poll.ready = !r_valid || i_advance;
    assign w_take       = i_poll.valid && i_poll.ready;

    // valid flag
    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.poll_valid    <= i_poll.poll_valid;
            r_item.raw_gpio      <= i_poll.raw_gpio;
            r_item.read_ok       <= i_poll.read_ok;
            r_item.prime         <= i_poll.prime;
            r_item.take_pressed  <= i_poll.take_pressed;
            r_item.take_released <= i_poll.take_released;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/dbe_filter.sv
// ----------------------------------------------------------------------------
// dbe_filter: debounce filter, edge latches and result register
// Updates sample ring, held state, latches: a poll per cycle unless stalled.
// ----------------------------------------------------------------------------
module dbe_filter
    import dbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [BTN_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    input  t_poll            i_item,
    output logic             o_advance,
    dbe_result_if.source     o_result
);

    logic [BTN_W-1:0]  r_mask;
    logic [BTN_W-1:0]  r_hist [HISTORY_DEPTH];
    logic [BTN_W-1:0]  n_hist [HISTORY_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [BTN_W-1:0]  r_held;
    logic [BTN_W-1:0]  n_held;
    logic [BTN_W-1:0]  r_pressed;
    logic [BTN_W-1:0]  n_pressed;
    logic [BTN_W-1:0]  r_released;
    logic [BTN_W-1:0]  n_released;
    logic [BTN_W-1:0]  r_raw;
    logic [BTN_W-1:0]  n_raw;
    logic              r_link;
    logic              n_link;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_res;
    t_result           n_res;

    logic [BTN_W-1:0]  w_sample;
    logic [BTN_W-1:0]  w_all;
    logic [BTN_W-1:0]  w_any;
    logic [BTN_W-1:0]  w_filt;
    logic              w_step;

    // stage moves when the result register is free or being drained
    assign o_advance = !r_out_valid || o_result.ready;
    assign w_step    = i_valid && o_advance;
    assign w_sample  = ~i_item.raw_gpio & r_mask;

    // ring with the new sample written at the current slot
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (r_slot == SLOT_W'(i)) begin
                n_hist[i] = w_sample;
            end else begin
                n_hist[i] = r_hist[i];
            end
        end
    end

    // agreement across all ring entries
    always_comb begin
        w_all = '1;
        w_any = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            w_all = w_all & n_hist[i];
            w_any = w_any | n_hist[i];
        end
        w_filt = (r_held & w_any) | w_all;
    end

    // next state and result
    always_comb begin
        n_slot      = r_slot;
        n_held      = r_held;
        n_pressed   = r_pressed;
        n_released  = r_released;
        n_raw       = r_raw;
        n_link      = r_link;
        n_out_valid = r_out_valid;
        n_res       = r_res;
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_step) begin
            if (i_item.poll_valid) begin
                if (i_item.prime) begin
                    n_slot     = '0;
                    n_pressed  = '0;
                    n_released = '0;
                    n_link     = i_item.read_ok;
                    n_held     = i_item.read_ok ? w_sample : '0;
                    if (i_item.read_ok) begin
                        n_raw = i_item.raw_gpio;
                    end
                end else if (i_item.read_ok) begin
                    n_link     = 1'b1;
                    n_raw      = i_item.raw_gpio;
                    n_held     = w_filt;
                    n_pressed  = r_pressed | (w_filt & ~r_held);
                    n_released = r_released | (r_held & ~w_filt);
                    n_slot     = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                end else begin
                    n_link = 1'b0;
                end
            end
            // report before the take flags clear the latches
            n_res.held           = n_held;
            n_res.pressed_edges  = n_pressed;
            n_res.released_edges = n_released;
            n_res.raw_last       = n_raw;
            n_res.online         = n_link;
            n_out_valid          = 1'b1;
            if (i_item.take_pressed) begin
                n_pressed = '0;
            end
            if (i_item.take_released) begin
                n_released = '0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MASK_RESET;
            r_slot      <= '0;
            r_held      <= '0;
            r_pressed   <= '0;
            r_released  <= '0;
            r_raw       <= RAW_RESET;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            r_slot      <= n_slot;
            r_held      <= n_held;
            r_pressed   <= n_pressed;
            r_released  <= n_released;
            r_raw       <= n_raw;
            r_link      <= n_link;
            r_out_valid <= n_out_valid;
        end
    end

    // sample ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_step && i_item.poll_valid && i_item.read_ok) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= i_item.prime ? w_sample : n_hist[i];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.held           = r_res.held;
    assign o_result.pressed_edges  = r_res.pressed_edges;
    assign o_result.released_edges = r_res.released_edges;
    assign o_result.raw_last       = r_res.raw_last;
    assign o_result.online         = r_res.online;

    // ring slot stays inside the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(HISTORY_DEPTH - 1))
        else $error("history slot out of range");

    // a prime reports no latched edges
    a_prime_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && i_item.poll_valid && i_item.prime
        |=> r_res.pressed_edges == '0 && r_res.released_edges == '0)
        else $error("prime left edges latched");

    // a failed read reports the link down
    a_fail_offline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && i_item.poll_valid && !i_item.read_ok |=> !r_res.online)
        else $error("failed read reported online");

    // a successful prime reports held equal to its masked sample
    a_prime_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && i_item.poll_valid && i_item.prime && i_item.read_ok
        |=> r_res.held == $past(w_sample))
        else $error("prime held mismatch");

endmodule

### sv/button_debounce_edge_latch_top.sv
// ----------------------------------------------------------------------------
// button_debounce_edge_latch_top: eight-button debounce with edge latches
// Filters active-low button reads and reports held state and latched edges.
// ----------------------------------------------------------------------------
// Accepts one poll transfer per clock and returns exactly one result transfer
// for each. Each poll passes the input register, then filter logic into the
// result register, on its way to a result transfer. The filter state
// update is combinational AND/OR logic over the three-entry sample ring,
// so polls may arrive every cycle; only a stalled result channel holds off
// input once both registers are full. Write button_mask only while no poll
// is in flight.
module button_debounce_edge_latch_top
    import dbe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,
    dbe_poll_if.sink     i_poll,
    dbe_result_if.source o_result
);

    logic  w_valid;
    logic  w_advance;
    t_poll w_item;

    // input register
    dbe_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_poll    (i_poll),
        .i_advance (w_advance),
        .o_valid   (w_valid),
        .o_item    (w_item)
    );

    // filter, latches and result register
    dbe_filter u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_valid),
        .i_item      (w_item),
        .o_advance   (w_advance),
        .o_result    (o_result)
    );

endmodule

### test/dbe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbe_checker: report predictor and scoreboard for the button debounce block
// Watches the config port and both channels, predicts one report per poll
// transfer and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module dbe_checker
    import dbe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [BTN_W-1:0] i_cfg_wdata,
    dbe_poll_if              i_poll,
    dbe_result_if            i_result,
    output int               o_fail_count,
    output int               o_pending
);

    // predicted filter state
    logic [BTN_W-1:0] mask_q;
    logic [BTN_W-1:0] hist_q [HISTORY_DEPTH];
    int               slot_q;
    logic [BTN_W-1:0] held_q;
    logic [BTN_W-1:0] pressed_q;
    logic [BTN_W-1:0] released_q;
    logic [BTN_W-1:0] last_raw_q;
    logic             link_q;

    t_result expected_reports [$];
    int      fails = 0;

    // advance the predicted state by one poll and build its report
    task automatic predict_report(input t_poll p, output t_result r);
        logic [BTN_W-1:0] sample;
        logic [BTN_W-1:0] all_pressed;
        logic [BTN_W-1:0] any_pressed;
        logic [BTN_W-1:0] prev_held;
        sample = ~p.raw_gpio & mask_q;
        if (p.poll_valid) begin
            if (p.prime) begin
                held_q     = '0;
                pressed_q  = '0;
                released_q = '0;
                slot_q     = 0;
                link_q     = p.read_ok;
                // a good read fills the whole ring, no edges latched
                if (p.read_ok) begin
                    last_raw_q = p.raw_gpio;
                    for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] = sample;
                    held_q = sample;
                end
            end else if (p.read_ok) begin
                link_q         = 1'b1;
                last_raw_q     = p.raw_gpio;
                hist_q[slot_q] = sample;
                slot_q         = (slot_q == HISTORY_DEPTH - 1) ? 0 : slot_q + 1;
                all_pressed    = '1;
                any_pressed    = '0;
                for (int i = 0; i < HISTORY_DEPTH; i++) begin
                    all_pressed = all_pressed & hist_q[i];
                    any_pressed = any_pressed | hist_q[i];
                end
                prev_held  = held_q;
                held_q     = (held_q & any_pressed) | all_pressed;
                pressed_q  = pressed_q | (held_q & ~prev_held);
                released_q = released_q | (prev_held & ~held_q);
            end else begin
                // failed read only drops the link
                link_q = 1'b0;
            end
        end
        r.held           = held_q;
        r.pressed_edges  = pressed_q;
        r.released_edges = released_q;
        r.raw_last       = last_raw_q;
        r.online         = link_q;
        // takes clear the latches after the report
        if (p.take_pressed)  pressed_q  = '0;
        if (p.take_released) released_q = '0;
    endtask

    task automatic check_field(input string field_name, input logic [BTN_W-1:0] want_v,
                               input logic [BTN_W-1:0] got_v);
        if (want_v !== got_v) begin
            fails++;
            $error("%s: expected %0h, actual %0h", field_name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_poll   poll_item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mask_q     = MASK_RESET;
            for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] = '0;
            slot_q     = 0;
            held_q     = '0;
            pressed_q  = '0;
            released_q = '0;
            last_raw_q = RAW_RESET;
            link_q     = 1'b0;
            expected_reports.delete();
        end else begin
            // result transfer against the oldest prediction
            if (i_result.valid && i_result.ready) begin
                got.held           = i_result.held;
                got.pressed_edges  = i_result.pressed_edges;
                got.released_edges = i_result.released_edges;
                got.raw_last       = i_result.raw_last;
                got.online         = i_result.online;
                if (expected_reports.size() == 0) begin
                    fails++;
                    $error("result transfer with no report expected");
                end else begin
                    want = expected_reports.pop_front();
                    check_field("held", want.held, got.held);
                    check_field("pressed_edges", want.pressed_edges, got.pressed_edges);
                    check_field("released_edges", want.released_edges, got.released_edges);
                    check_field("raw_last", want.raw_last, got.raw_last);
                    check_field("online", {7'd0, want.online}, {7'd0, got.online});
                end
            end
            // mask register write
            if (i_cfg_we) mask_q = i_cfg_wdata;
            // poll transfer
            if (i_poll.valid && i_poll.ready) begin
                poll_item.poll_valid    = i_poll.poll_valid;
                poll_item.raw_gpio      = i_poll.raw_gpio;
                poll_item.read_ok       = i_poll.read_ok;
                poll_item.prime         = i_poll.prime;
                poll_item.take_pressed  = i_poll.take_pressed;
                poll_item.take_released = i_poll.take_released;
                predict_report(poll_item, want);
                expected_reports.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_reports.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the button debounce block
// Drives directed and run-shaped random polls through several mask settings
// with random idle bursts on both channels; the checker scores the reports.
// ----------------------------------------------------------------------------
module testbench;
    import dbe_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [BTN_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    bit               quiet = 1'b0;

    // random run state: a stable target byte held for a few polls
    logic [BTN_W-1:0] target_raw = '0;
    int               run_left   = 0;

    dbe_poll_if   poll_ch ();
    dbe_result_if result_ch ();

    button_debounce_edge_latch_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_poll      (poll_ch),
        .o_result    (result_ch)
    );

    dbe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_poll       (poll_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    function automatic t_poll make_poll(bit pv, logic [BTN_W-1:0] raw, bit ok, bit pr,
                                        bit tp, bit tr);
        t_poll p;
        p.poll_valid    = pv;
        p.raw_gpio      = raw;
        p.read_ok       = ok;
        p.prime         = pr;
        p.take_pressed  = tp;
        p.take_released = tr;
        return p;
    endfunction

    // one poll transfer, with an optional idle burst ahead of it
    task automatic send_poll(input t_poll p);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid         <= 1'b1;
        poll_ch.poll_valid    <= p.poll_valid;
        poll_ch.raw_gpio      <= p.raw_gpio;
        poll_ch.read_ok       <= p.read_ok;
        poll_ch.prime         <= p.prime;
        poll_ch.take_pressed  <= p.take_pressed;
        poll_ch.take_released <= p.take_released;
        @(posedge clk);
        while (!poll_ch.ready) @(posedge clk);
    endtask

    // mostly stable runs with bounce, plus acks, failed reads and primes
    task automatic next_random_poll(output t_poll p);
        int pick;
        logic [BTN_W-1:0] raw;
        if (run_left == 0) begin
            target_raw = BTN_W'($urandom);
            run_left   = $urandom_range(1, 6);
        end
        run_left--;
        raw = target_raw;
        if ($urandom_range(0, 3) == 0) raw = raw ^ (8'd1 << $urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 70)      p = make_poll(1'b1, raw, 1'b1, 1'b0, 1'b0, 1'b0);
        else if (pick < 78) p = make_poll(1'b0, BTN_W'($urandom), 1'($urandom),
                                          1'($urandom), 1'b0, 1'b0);
        else if (pick < 85) p = make_poll(1'b1, BTN_W'($urandom), 1'b0, 1'b0, 1'b0, 1'b0);
        else if (pick < 92) p = make_poll(1'b1, target_raw, 1'b1, 1'b1, 1'b0, 1'b0);
        else                p = make_poll(1'b1, BTN_W'($urandom), 1'($urandom), 1'b1,
                                          1'b0, 1'b0);
        p.take_pressed  = ($urandom_range(0, 3) == 0);
        p.take_released = ($urandom_range(0, 3) == 0);
    endtask

    // stop polling and wait for every report to come back
    task automatic drain;
        poll_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mask(input logic [BTN_W-1:0] m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side stalls in random bursts
    initial begin : result_sink
        int stall_left;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (quiet) begin
                stall_left = 0;
                result_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_poll            directed [$];
        t_poll            p;
        logic [BTN_W-1:0] phase_mask [6];
        int               phase_items [6];
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        poll_ch.valid         = 1'b0;
        poll_ch.poll_valid    = 1'b0;
        poll_ch.raw_gpio      = '0;
        poll_ch.read_ok       = 1'b0;
        poll_ch.prime         = 1'b0;
        poll_ch.take_pressed  = 1'b0;
        poll_ch.take_released = 1'b0;
        phase_mask  = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF};
        phase_items = '{180, 150, 250, 200, 200, 200};
        phase_mask[4] = BTN_W'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: primes, full press and release, bounce, failed reads, takes
        directed.push_back(make_poll(1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
        directed.push_back(make_poll(1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hAA, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h55, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hAA, 1'b1, 1'b0, 1'b1, 1'b1));
        directed.push_back(make_poll(1'b1, 8'hF0, 1'b0, 1'b1, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'hF0, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h0F, 1'b1, 1'b0, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b1, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
        directed.push_back(make_poll(1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
        directed.push_back(make_poll(1'b0, 8'hAA, 1'b0, 1'b1, 1'b1, 1'b1));
        foreach (directed[i]) send_poll(directed[i]);

        // random phases, each under its own mask; the last one runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_mask(phase_mask[ph]);
            end
            if (ph == 5) quiet = 1'b1;
            for (int n = 0; n < phase_items[ph]; n++) begin
                next_random_poll(p);
                send_poll(p);
            end
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
